### src/gpc_pkg.sv
// shared constants and helpers for the glyph pixel compositor
package gpc_pkg;

  localparam int POS_W    = 16;
  localparam int CHAN_W   = 8;
  localparam int CLIP_W   = 15;
  localparam int COLOR_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W   = 2 * CHAN_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_RIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_BOTTOM = 3'd4;

  // request modes
  localparam logic MODE_TINT = 1'b0;
  localparam logic MODE_OVER = 1'b1;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [PROD_W-1:0] prod_t;

  // exact x / 255 for x below 255 * 256, which covers every 8x8 product sum here
  function automatic chan_t div255(input prod_t x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[PROD_W-1:CHAN_W]};
    return t[PROD_W-1:CHAN_W];
  endfunction

endpackage

### src/glyph_pixel_compositor.sv
// glyph pixel compositor top level: four stage blend pipeline and config registers
//
//  channel  ports                              flow control
//  -------  ---------------------------------  -------------------------------
//  request  start, busy, in_*                  taken when start && !busy
//  result   out_valid, out_*                   one-cycle strobe, never held off
//  config   cfg_valid, cfg_ready, cfg_index,   written when cfg_valid && cfg_ready
//           cfg_data
//
//  one pixel enters every cycle and its result passes through four register stages:
//  clip test and coverage product, divide by 255, channel products, divide and
//  final select
//  rst_n is synchronous and active low; it empties the pipeline and clears config
//  busy stays low and cfg_ready stays high: nothing downstream can stall
module glyph_pixel_compositor #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [gpc_pkg::POS_W-1:0]     in_pos_x,
  input  logic [gpc_pkg::POS_W-1:0]     in_pos_y,
  input  logic [gpc_pkg::CHAN_W-1:0]    in_src_blue,
  input  logic [gpc_pkg::CHAN_W-1:0]    in_src_green,
  input  logic [gpc_pkg::CHAN_W-1:0]    in_src_red,
  input  logic [gpc_pkg::CHAN_W-1:0]    in_src_level,
  input  logic [gpc_pkg::CHAN_W-1:0]    in_dst_blue,
  input  logic [gpc_pkg::CHAN_W-1:0]    in_dst_green,
  input  logic [gpc_pkg::CHAN_W-1:0]    in_dst_red,
  input  logic [gpc_pkg::CHAN_W-1:0]    in_dst_alpha,
  // result channel
  output logic                          out_valid,
  output logic                          out_write_enable,
  output logic [gpc_pkg::CHAN_W-1:0]    out_blue,
  output logic [gpc_pkg::CHAN_W-1:0]    out_green,
  output logic [gpc_pkg::CHAN_W-1:0]    out_red,
  output logic [gpc_pkg::CHAN_W-1:0]    out_alpha,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gpc_pkg::COLOR_W-1:0]   cfg_data
);
  import gpc_pkg::*;

  localparam int CMP_W = POS_W + 1;   // signed compare width

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [COLOR_W-1:0] text_color_r;
  logic [CLIP_W-1:0]  clip_left_r, clip_top_r, clip_right_r, clip_bottom_r;
  logic               cfg_wr;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r  <= '0;
      clip_left_r   <= '0;
      clip_top_r    <= '0;
      clip_right_r  <= '0;
      clip_bottom_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_TEXT_COLOR:  text_color_r  <= cfg_data;
        CFG_CLIP_LEFT:   clip_left_r   <= cfg_data[CLIP_W-1:0];
        CFG_CLIP_TOP:    clip_top_r    <= cfg_data[CLIP_W-1:0];
        CFG_CLIP_RIGHT:  clip_right_r  <= cfg_data[CLIP_W-1:0];
        CFG_CLIP_BOTTOM: clip_bottom_r <= cfg_data[CLIP_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // text colour fields; zero alpha means opaque
  chan_t col_a, col_r, col_g, col_b;
  assign col_a = (text_color_r[31:24] == '0) ? CHAN_MAX : text_color_r[31:24];
  assign col_r = text_color_r[23:16];
  assign col_g = text_color_r[15:8];
  assign col_b = text_color_r[7:0];

  // ---------------------------------------------------------------------------
  // stage 1: clip test, coverage times colour alpha
  // ---------------------------------------------------------------------------
  logic                    req_acc;
  logic signed [CMP_W-1:0] pos_x_s, pos_y_s;
  logic signed [CMP_W-1:0] cl_s, ct_s, cr_s, cb_s;
  logic                    in_clip;

  assign req_acc = start && !busy;

  // keep the low COORD_BITS bits and sign-extend
  assign pos_x_s = {{(CMP_W-COORD_BITS){in_pos_x[COORD_BITS-1]}}, in_pos_x[COORD_BITS-1:0]};
  assign pos_y_s = {{(CMP_W-COORD_BITS){in_pos_y[COORD_BITS-1]}}, in_pos_y[COORD_BITS-1:0]};
  assign cl_s = signed'({{(CMP_W-CLIP_W){1'b0}}, clip_left_r});
  assign ct_s = signed'({{(CMP_W-CLIP_W){1'b0}}, clip_top_r});
  assign cr_s = signed'({{(CMP_W-CLIP_W){1'b0}}, clip_right_r});
  assign cb_s = signed'({{(CMP_W-CLIP_W){1'b0}}, clip_bottom_r});

  // an empty rectangle fails one of these by itself
  assign in_clip = (pos_x_s >= cl_s) && (pos_x_s < cr_s) &&
                   (pos_y_s >= ct_s) && (pos_y_s < cb_s);

  logic  v1_r;
  logic  mode1_r, we1_r;
  chan_t lvl1_r, sb1_r, sg1_r, sr1_r, db1_r, dg1_r, dr1_r, da1_r;
  prod_t cov1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= req_acc;
    end
  end

  always_ff @(posedge clk) begin
    mode1_r <= in_req_type;
    we1_r   <= in_clip && (in_src_level != '0);
    lvl1_r  <= in_src_level;
    // source colour only adds in source-over mode
    sb1_r   <= (in_req_type == MODE_OVER) ? in_src_blue  : '0;
    sg1_r   <= (in_req_type == MODE_OVER) ? in_src_green : '0;
    sr1_r   <= (in_req_type == MODE_OVER) ? in_src_red   : '0;
    db1_r   <= in_dst_blue;
    dg1_r   <= in_dst_green;
    dr1_r   <= in_dst_red;
    da1_r   <= in_dst_alpha;
    cov1_r  <= prod_t'(in_src_level * col_a);
  end

  // ---------------------------------------------------------------------------
  // stage 2: effective alpha, coverage product over 255 or raw source alpha
  // ---------------------------------------------------------------------------
  logic  v2_r;
  logic  mode2_r, we2_r;
  chan_t a2_r, sb2_r, sg2_r, sr2_r, db2_r, dg2_r, dr2_r, da2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    mode2_r <= mode1_r;
    we2_r   <= we1_r;
    a2_r    <= (mode1_r == MODE_OVER) ? lvl1_r : div255(cov1_r);
    sb2_r   <= sb1_r;
    sg2_r   <= sg1_r;
    sr2_r   <= sr1_r;
    db2_r   <= db1_r;
    dg2_r   <= dg1_r;
    dr2_r   <= dr1_r;
    da2_r   <= da1_r;
  end

  // ---------------------------------------------------------------------------
  // stage 3: channel products, colour term only in tint mode
  // ---------------------------------------------------------------------------
  chan_t inv_a2;
  chan_t tb2, tg2, tr2;

  assign inv_a2 = CHAN_MAX - a2_r;
  assign tb2 = (mode2_r == MODE_TINT) ? col_b : '0;
  assign tg2 = (mode2_r == MODE_TINT) ? col_g : '0;
  assign tr2 = (mode2_r == MODE_TINT) ? col_r : '0;

  logic  v3_r;
  logic  we3_r;
  chan_t a3_r, sb3_r, sg3_r, sr3_r, db3_r, dg3_r, dr3_r, da3_r;
  prod_t pb3_r, pg3_r, pr3_r, pa3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  // c*a + d*(255-a) never exceeds 255*255, so 16 bits hold it
  always_ff @(posedge clk) begin
    we3_r <= we2_r;
    a3_r  <= a2_r;
    sb3_r <= sb2_r;
    sg3_r <= sg2_r;
    sr3_r <= sr2_r;
    db3_r <= db2_r;
    dg3_r <= dg2_r;
    dr3_r <= dr2_r;
    da3_r <= da2_r;
    pb3_r <= prod_t'(tb2 * a2_r) + prod_t'(db2_r * inv_a2);
    pg3_r <= prod_t'(tg2 * a2_r) + prod_t'(dg2_r * inv_a2);
    pr3_r <= prod_t'(tr2 * a2_r) + prod_t'(dr2_r * inv_a2);
    pa3_r <= prod_t'(da2_r * inv_a2);
  end

  // ---------------------------------------------------------------------------
  // stage 4: divide, add source, saturate alpha, pick blend or destination
  // ---------------------------------------------------------------------------
  chan_t         bl_b, bl_g, bl_r, bl_a;
  logic [CHAN_W:0] alpha_sum;

  // colour channels wrap to 8 bits
  assign bl_b = chan_t'(sb3_r + div255(pb3_r));
  assign bl_g = chan_t'(sg3_r + div255(pg3_r));
  assign bl_r = chan_t'(sr3_r + div255(pr3_r));
  assign alpha_sum = {1'b0, a3_r} + {1'b0, div255(pa3_r)};
  assign bl_a = alpha_sum[CHAN_W] ? CHAN_MAX : alpha_sum[CHAN_W-1:0];

  logic  v4_r, we4_r;
  chan_t ob4_r, og4_r, or4_r, oa4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r  <= 1'b0;
      we4_r <= 1'b0;
    end else begin
      v4_r  <= v3_r;
      we4_r <= v3_r && we3_r;
    end
  end

  always_ff @(posedge clk) begin
    ob4_r <= we3_r ? bl_b : db3_r;
    og4_r <= we3_r ? bl_g : dg3_r;
    or4_r <= we3_r ? bl_r : dr3_r;
    oa4_r <= we3_r ? bl_a : da3_r;
  end

  assign out_valid        = v4_r;
  assign out_write_enable = we4_r;
  assign out_blue         = ob4_r;
  assign out_green        = og4_r;
  assign out_red          = or4_r;
  assign out_alpha        = oa4_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // every accepted request yields its result on out_valid
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    req_acc |-> ##4 out_valid)
    else $error("accepted request produced no result");

  // no result strobe without a request in flight through the earlier stages
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(v3_r) && $past(v2_r, 2) && $past(v1_r, 3))
    else $error("result strobe without a request in flight");

  // write enable only ever rides on a result
  a_we_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_write_enable |-> out_valid)
    else $error("write enable outside a result");

  // an unwritten pixel passes the destination through untouched
  a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !we3_r |=> out_blue == $past(db3_r) && out_green == $past(dg3_r) &&
                       out_red == $past(dr3_r) && out_alpha == $past(da3_r))
    else $error("unwritten pixel altered");

endmodule

### dv/glyph_pixel_compositor_checker.sv
// request/result checker for the glyph pixel compositor: predicts each blended pixel
`timescale 1ns / 1ps
module glyph_pixel_compositor_checker #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_req_type,
  input  logic [gpc_pkg::POS_W-1:0]     in_pos_x,
  input  logic [gpc_pkg::POS_W-1:0]     in_pos_y,
  input  logic [gpc_pkg::CHAN_W-1:0]    in_src_blue,
  input  logic [gpc_pkg::CHAN_W-1:0]    in_src_green,
  input  logic [gpc_pkg::CHAN_W-1:0]    in_src_red,
  input  logic [gpc_pkg::CHAN_W-1:0]    in_src_level,
  input  logic [gpc_pkg::CHAN_W-1:0]    in_dst_blue,
  input  logic [gpc_pkg::CHAN_W-1:0]    in_dst_green,
  input  logic [gpc_pkg::CHAN_W-1:0]    in_dst_red,
  input  logic [gpc_pkg::CHAN_W-1:0]    in_dst_alpha,
  input  logic                          out_valid,
  input  logic                          out_write_enable,
  input  logic [gpc_pkg::CHAN_W-1:0]    out_blue,
  input  logic [gpc_pkg::CHAN_W-1:0]    out_green,
  input  logic [gpc_pkg::CHAN_W-1:0]    out_red,
  input  logic [gpc_pkg::CHAN_W-1:0]    out_alpha,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [gpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gpc_pkg::COLOR_W-1:0]   cfg_data,
  output int                            errors,
  output int                            pending
);
  import gpc_pkg::*;

  localparam int FULL = 255;

  typedef struct packed {
    logic  wr;
    chan_t blue;
    chan_t green;
    chan_t red;
    chan_t alpha;
  } pixel_out_t;

  // local copy of the register file
  logic [COLOR_W-1:0] text_color;
  logic [CLIP_W-1:0]  clip_l, clip_t, clip_r, clip_b;

  pixel_out_t blended_q[$];

  // low COORD_BITS bits, sign-extended
  function automatic int to_coord(input logic [POS_W-1:0] v);
    int u;
    int sb;
    sb = 1 << (COORD_BITS - 1);
    u  = int'(v) & ((1 << COORD_BITS) - 1);
    return (u ^ sb) - sb;
  endfunction

  function automatic int tint(input int c, input int a, input int d);
    return (c * a + d * (FULL - a)) / FULL;
  endfunction

  function automatic int over(input int s, input int sa, input int d);
    return (s + d * (FULL - sa) / FULL) & FULL;
  endfunction

  function automatic pixel_out_t blended_pixel();
    pixel_out_t r;
    int px, py, lvl, a, ca, na;
    logic in_clip;
    r.wr    = 1'b0;
    r.blue  = in_dst_blue;
    r.green = in_dst_green;
    r.red   = in_dst_red;
    r.alpha = in_dst_alpha;
    px  = to_coord(in_pos_x);
    py  = to_coord(in_pos_y);
    lvl = int'(in_src_level);
    in_clip = px >= int'(clip_l) && px < int'(clip_r) &&
              py >= int'(clip_t) && py < int'(clip_b);
    if (in_clip && lvl != 0) begin
      r.wr = 1'b1;
      if (in_req_type == MODE_TINT) begin
        // zero text alpha stands for opaque
        ca = int'(text_color[31:24]);
        if (ca == 0) ca = FULL;
        a = lvl * ca / FULL;
        r.blue  = chan_t'(tint(int'(text_color[7:0]), a, int'(in_dst_blue)));
        r.green = chan_t'(tint(int'(text_color[15:8]), a, int'(in_dst_green)));
        r.red   = chan_t'(tint(int'(text_color[23:16]), a, int'(in_dst_red)));
      end else begin
        a = lvl;
        r.blue  = chan_t'(over(int'(in_src_blue), a, int'(in_dst_blue)));
        r.green = chan_t'(over(int'(in_src_green), a, int'(in_dst_green)));
        r.red   = chan_t'(over(int'(in_src_red), a, int'(in_dst_red)));
      end
      na = a + int'(in_dst_alpha) * (FULL - a) / FULL;
      r.alpha = chan_t'(na > FULL ? FULL : na);
    end
    return r;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    pixel_out_t want;
    if (!rst_n) begin
      text_color = '0;
      clip_l     = '0;
      clip_t     = '0;
      clip_r     = '0;
      clip_b     = '0;
      blended_q.delete();
    end else begin
      if (out_valid) begin
        if (blended_q.size() == 0) begin
          $display("%0t: result with no request outstanding, actual we=%0b b=%0d g=%0d r=%0d a=%0d",
                   $time, out_write_enable, out_blue, out_green, out_red, out_alpha);
          errors++;
        end else begin
          want = blended_q.pop_front();
          check_field("write_enable", int'(want.wr), int'(out_write_enable));
          check_field("blue", int'(want.blue), int'(out_blue));
          check_field("green", int'(want.green), int'(out_green));
          check_field("red", int'(want.red), int'(out_red));
          check_field("alpha", int'(want.alpha), int'(out_alpha));
        end
      end
      if (start && !busy) blended_q.push_back(blended_pixel());
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TEXT_COLOR:  text_color = cfg_data;
          CFG_CLIP_LEFT:   clip_l = cfg_data[CLIP_W-1:0];
          CFG_CLIP_TOP:    clip_t = cfg_data[CLIP_W-1:0];
          CFG_CLIP_RIGHT:  clip_r = cfg_data[CLIP_W-1:0];
          CFG_CLIP_BOTTOM: clip_b = cfg_data[CLIP_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= blended_q.size();
  end

endmodule

### dv/glyph_pixel_compositor_tb.sv
// top-level testbench for the glyph pixel compositor: stimulus, config phases and verdict
`timescale 1ns / 1ps
module glyph_pixel_compositor_tb;
  import gpc_pkg::*;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int DRAIN_CYCLES    = 8;     // pipeline is four deep, leave some slack
  localparam int TIMEOUT_NS      = 4_000_000;
  localparam int CLIP_MAX        = 32767;
  // index past the last register, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef struct {
    logic             mode;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    chan_t            sb, sg, sr, lvl;
    chan_t            db, dg, dr, da;
  } pixel_req_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // every block input starts at a known value
  logic                 start        = 1'b0;
  logic                 in_req_type  = MODE_TINT;
  logic [POS_W-1:0]     in_pos_x     = '0;
  logic [POS_W-1:0]     in_pos_y     = '0;
  logic [CHAN_W-1:0]    in_src_blue  = '0;
  logic [CHAN_W-1:0]    in_src_green = '0;
  logic [CHAN_W-1:0]    in_src_red   = '0;
  logic [CHAN_W-1:0]    in_src_level = '0;
  logic [CHAN_W-1:0]    in_dst_blue  = '0;
  logic [CHAN_W-1:0]    in_dst_green = '0;
  logic [CHAN_W-1:0]    in_dst_red   = '0;
  logic [CHAN_W-1:0]    in_dst_alpha = '0;
  logic                 cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = CFG_TEXT_COLOR;
  logic [COLOR_W-1:0]   cfg_data     = '0;

  logic                 busy;
  logic                 out_valid;
  logic                 out_write_enable;
  logic [CHAN_W-1:0]    out_blue, out_green, out_red, out_alpha;
  logic                 cfg_ready;

  int errors;
  int pending;

  // current clip window, used to aim positions at its edges
  int win_l, win_t, win_r, win_b;
  // request bursts: how many requests are left before the next gap
  int burst_left;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  glyph_pixel_compositor u_dut (.*);

  glyph_pixel_compositor_checker u_checker (.*);

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("[glyph_pixel_compositor] ERROR");
    $finish;
  end

  function automatic pixel_req_t mk_pixel(input logic mode, input int x, input int y,
                                          input int sb, input int sg, input int sr,
                                          input int lvl, input int db, input int dg,
                                          input int dr, input int da);
    pixel_req_t p;
    p.mode = mode;
    p.x    = x[POS_W-1:0];
    p.y    = y[POS_W-1:0];
    p.sb   = sb[CHAN_W-1:0];
    p.sg   = sg[CHAN_W-1:0];
    p.sr   = sr[CHAN_W-1:0];
    p.lvl  = lvl[CHAN_W-1:0];
    p.db   = db[CHAN_W-1:0];
    p.dg   = dg[CHAN_W-1:0];
    p.dr   = dr[CHAN_W-1:0];
    p.da   = da[CHAN_W-1:0];
    return p;
  endfunction

  // mostly a couple of pixels either side of the window, otherwise anywhere
  function automatic int pick_axis(input int lo, input int hi);
    if (hi > lo && $urandom_range(0, 3) != 0)
      return lo - 2 + int'($urandom_range(0, hi - lo + 3));
    return int'($urandom_range(0, 16'hffff));
  endfunction

  function automatic int pick_level();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 255;
      default: return int'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_req_t random_pixel();
    return mk_pixel(1'($urandom_range(0, 1)), pick_axis(win_l, win_r),
                    pick_axis(win_t, win_b),
                    $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                    pick_level(),
                    $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255));
  endfunction

  // hold start high until the request is taken
  task automatic push_pixel(input pixel_req_t p);
    start        <= 1'b1;
    in_req_type  <= p.mode;
    in_pos_x     <= p.x;
    in_pos_y     <= p.y;
    in_src_blue  <= p.sb;
    in_src_green <= p.sg;
    in_src_red   <= p.sr;
    in_src_level <= p.lvl;
    in_dst_blue  <= p.db;
    in_dst_green <= p.dg;
    in_dst_red   <= p.dr;
    in_dst_alpha <= p.da;
    do @(posedge clk); while (busy);
  endtask

  // random request with burst and gap handling around it
  task automatic push_streamed(input pixel_req_t p);
    push_pixel(p);
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
  endtask

  // stop sending and wait until every predicted pixel has come back
  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // clip registers are 15 bits wide, junk in the upper data bits must be dropped
  task automatic set_clip(input int l, input int t, input int r, input int b);
    write_reg(CFG_CLIP_LEFT,   ($urandom() & 32'hffff8000) | l);
    write_reg(CFG_CLIP_TOP,    ($urandom() & 32'hffff8000) | t);
    write_reg(CFG_CLIP_RIGHT,  ($urandom() & 32'hffff8000) | r);
    write_reg(CFG_CLIP_BOTTOM, ($urandom() & 32'hffff8000) | b);
    win_l = l;
    win_t = t;
    win_r = r;
    win_b = b;
  endtask

  task automatic configure_phase(input int clip_sel, input int color_sel);
    int l, t, r, b;
    logic [COLOR_W-1:0] color;
    case (clip_sel)
      0: begin  // whole coordinate space
        l = 0; t = 0; r = CLIP_MAX; b = CLIP_MAX;
      end
      1: begin  // empty window, right not past left
        l = $urandom_range(0, CLIP_MAX); r = $urandom_range(0, l);
        t = $urandom_range(0, CLIP_MAX); b = $urandom_range(0, CLIP_MAX);
      end
      2: begin  // small window somewhere
        l = $urandom_range(0, 32000); r = l + $urandom_range(1, 48);
        t = $urandom_range(0, 32000); b = t + $urandom_range(1, 48);
      end
      3: begin  // small window at the origin
        l = 0; t = 0; r = $urandom_range(1, 64); b = $urandom_range(1, 64);
      end
      4: begin  // window against the far edges
        l = $urandom_range(32700, CLIP_MAX - 1); r = CLIP_MAX;
        t = $urandom_range(32700, CLIP_MAX - 1); b = CLIP_MAX;
      end
      default: begin
        l = $urandom_range(0, CLIP_MAX); r = $urandom_range(0, CLIP_MAX);
        t = $urandom_range(0, CLIP_MAX); b = $urandom_range(0, CLIP_MAX);
      end
    endcase
    color = $urandom();
    case (color_sel)
      1: color[31:24] = 8'h00;  // zero alpha reads as opaque
      2: color[31:24] = 8'hff;
      3: color = '0;
      4: color = '1;
      default: ;
    endcase
    write_reg(CFG_TEXT_COLOR, color);
    set_clip(l, t, r, b);
  endtask

  initial begin
    int x0, y0;
    win_l = 0;
    win_t = 0;
    win_r = 0;
    win_b = 0;
    burst_left = 1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers straight out of reset: empty clip window, nothing is written
    push_pixel(mk_pixel(MODE_TINT, 0, 0, 0, 0, 0, 255, 11, 22, 33, 44));
    push_pixel(mk_pixel(MODE_OVER, 0, 0, 255, 255, 255, 255, 55, 66, 77, 88));
    quiesce();

    // directed part: window edges, both modes, level extremes
    write_reg(CFG_TEXT_COLOR, 32'h0040_80c0);
    set_clip(10, 20, 100, 200);
    write_reg(CFG_SPARE, $urandom());
    push_pixel(mk_pixel(MODE_TINT, 10, 20, 0, 0, 0, 255, 1, 2, 3, 4));     // top-left corner
    push_pixel(mk_pixel(MODE_TINT, 99, 199, 0, 0, 0, 1, 200, 150, 100, 50)); // last inside
    push_pixel(mk_pixel(MODE_TINT, 50, 50, 9, 9, 9, 0, 12, 34, 56, 78));   // zero coverage
    push_pixel(mk_pixel(MODE_TINT, 100, 50, 0, 0, 0, 255, 5, 6, 7, 8));    // right edge out
    push_pixel(mk_pixel(MODE_TINT, 9, 50, 0, 0, 0, 255, 5, 6, 7, 8));      // left edge out
    push_pixel(mk_pixel(MODE_TINT, 50, 200, 0, 0, 0, 255, 5, 6, 7, 8));    // bottom edge out
    push_pixel(mk_pixel(MODE_TINT, 50, 19, 0, 0, 0, 255, 5, 6, 7, 8));     // top edge out
    push_pixel(mk_pixel(MODE_TINT, -32768, 50, 0, 0, 0, 255, 1, 1, 1, 1));
    push_pixel(mk_pixel(MODE_TINT, 32767, 50, 0, 0, 0, 255, 1, 1, 1, 1));
    push_pixel(mk_pixel(MODE_OVER, 50, -32768, 1, 1, 1, 255, 1, 1, 1, 1));
    push_pixel(mk_pixel(MODE_OVER, 50, 32767, 1, 1, 1, 255, 1, 1, 1, 1));
    // premultiplied colour wraps past 8 bits
    push_pixel(mk_pixel(MODE_OVER, 50, 50, 255, 255, 255, 1, 255, 255, 255, 255));
    push_pixel(mk_pixel(MODE_OVER, 50, 50, 0, 0, 0, 255, 255, 255, 255, 255));
    push_pixel(mk_pixel(MODE_OVER, 50, 50, 200, 100, 50, 0, 10, 20, 30, 40)); // zero alpha
    push_pixel(mk_pixel(MODE_OVER, 60, 60, 255, 255, 255, 255, 0, 0, 0, 0));
    push_pixel(mk_pixel(MODE_TINT, 60, 60, 255, 255, 255, 128, 0, 0, 0, 0));  // source colour unused
    push_pixel(mk_pixel(MODE_TINT, 60, 60, 0, 0, 0, 255, 255, 255, 255, 255));
    quiesce();

    // full window, opaque white text, then a barely visible text alpha
    write_reg(CFG_TEXT_COLOR, 32'hffff_ffff);
    set_clip(0, 0, CLIP_MAX, CLIP_MAX);
    push_pixel(mk_pixel(MODE_TINT, 0, 0, 0, 0, 0, 255, 0, 0, 0, 0));
    push_pixel(mk_pixel(MODE_TINT, 32766, 32766, 0, 0, 0, 200, 90, 90, 90, 90));
    push_pixel(mk_pixel(MODE_TINT, 32767, 32766, 0, 0, 0, 200, 90, 90, 90, 90));
    quiesce();
    write_reg(CFG_TEXT_COLOR, 32'h0100_0000);
    push_pixel(mk_pixel(MODE_TINT, 5, 5, 0, 0, 0, 255, 128, 128, 128, 128));
    push_pixel(mk_pixel(MODE_OVER, 5, 5, 10, 20, 30, 40, 128, 128, 128, 128));

    // random phases, each under its own colour and clip window
    for (int ph = 0; ph < PHASES; ph++) begin
      quiesce();
      if (ph < 5) configure_phase(ph, ph);
      else configure_phase($urandom_range(0, 5), $urandom_range(0, 4));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // one mid-phase pause until the pipeline has fully emptied
        if (ph == 2 && i == ITEMS_PER_PHASE / 2) quiesce();
        // a few requests aimed at the window corners
        if ($urandom_range(0, 15) == 0) begin
          x0 = $urandom_range(0, 1) ? win_l : win_r - 1;
          y0 = $urandom_range(0, 1) ? win_t : win_b - 1;
          push_streamed(mk_pixel(1'($urandom_range(0, 1)), x0, y0,
                                 $urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 255), pick_level(),
                                 $urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 255), $urandom_range(0, 255)));
        end else begin
          push_streamed(random_pixel());
        end
      end
    end

    // let the pipeline empty, bounded, then give the verdict
    start <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < 1000 && pending != 0; n++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending != 0)
      $display("%0t: %0d predicted pixels never came back", $time, pending);
    if (errors == 0 && pending == 0) begin
      $display("[glyph_pixel_compositor] OK");
    end else begin
      $display("[glyph_pixel_compositor] ERROR");
    end
    $finish;
  end

endmodule
